@@ src/lbfw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfw_pkg
// shared constants, types and state encodings of the led bit-plane frame
// writer
// ----------------------------------------------------------------------------
package lbfw_pkg;

    localparam int ROW_LENGTH     = 60;
    localparam int STRIP_LENGTH   = 300;
    localparam int STRIP_COUNT    = 8;
    localparam int PIXEL_COUNT    = 2400;
    localparam int BITS_PER_PIXEL = 24;
    localparam int STORE_DEPTH    = STRIP_LENGTH * BITS_PER_PIXEL;

    localparam int ADDR_W  = 13;
    localparam int INDEX_W = 12;
    localparam int COLOR_W = 24;
    localparam int LANE_W  = 3;

    localparam int RECIP_SHIFT = 16;
    localparam logic [11:0] ROW_RECIP   = 12'((1 << RECIP_SHIFT) / ROW_LENGTH);
    localparam logic [11:0] STRIP_RECIP = 12'((1 << RECIP_SHIFT) / STRIP_LENGTH);

    localparam logic [ADDR_W-1:0] STORE_BYTES = ADDR_W'(STORE_DEPTH);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [0:0] {
        CMD_SET  = 1'b0,
        CMD_READ = 1'b1
    } t_command;

    typedef struct packed {
        logic                is_read;
        logic [ADDR_W-1:0]   addr;
        logic [LANE_W-1:0]   strip;
        logic [COLOR_W-1:0]  grb;
    } t_job;

    typedef enum logic [2:0] {
        F_IDLE,
        F_ROW_EST,
        F_ROW_REM,
        F_MIRROR,
        F_STRIP_EST,
        F_STRIP_REM,
        F_STRIP_FIX,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_RMW,
        B_READ
    } t_back_state;

endpackage

@@ src/lbfw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfw_front
// accepts commands, drops out-of-range pixels, applies the serpentine
// mirror and splits the index into strip and offset
// ----------------------------------------------------------------------------
module lbfw_front import lbfw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [0:0]         i_command,
    input  logic [INDEX_W-1:0] i_pixel_index,
    input  logic [COLOR_W-1:0] i_pixel_color,
    input  logic [ADDR_W-1:0]  i_byte_address,
    input  logic               i_clearing,
    input  logic               i_full,
    output logic               o_push,
    output t_job               o_job
);

    t_front_state       r_state, n_state;
    t_command           r_cmd;
    logic [INDEX_W-1:0] r_idx;
    logic [COLOR_W-1:0] r_color;
    logic [ADDR_W-1:0]  r_addr;
    logic [6:0]         r_q;
    logic [9:0]         r_rem;

    logic               accept;
    logic [23:0]        row_prod;
    logic [23:0]        strip_prod;
    logic [ADDR_W-1:0]  row_rem_raw;
    logic [ADDR_W-1:0]  strip_rem_raw;
    logic               row_wrap;
    logic [6:0]         row_fix;
    logic [9:0]         row_rem_fix;
    logic [ADDR_W-1:0]  mirrored;
    logic               strip_wrap;
    logic [6:0]         strip_fix;
    logic [9:0]         off_fix;
    logic               strip_drop;
    logic [13:0]        base;

    function automatic logic [COLOR_W-1:0] to_grb(input logic [COLOR_W-1:0] rgb);
        return {rgb[15:8], rgb[23:16], rgb[7:0]};
    endfunction

    // row and strip split by reciprocal estimate plus one correction step
    always_comb begin
        row_prod      = 24'(r_idx) * 24'(ROW_RECIP);
        strip_prod    = 24'(r_idx) * 24'(STRIP_RECIP);
        row_rem_raw   = ADDR_W'(r_idx) - ADDR_W'(r_q) * ADDR_W'(ROW_LENGTH);
        strip_rem_raw = ADDR_W'(r_idx) - ADDR_W'(r_q) * ADDR_W'(STRIP_LENGTH);
        row_wrap      = (r_rem >= 10'(ROW_LENGTH));
        row_fix       = r_q + 7'(row_wrap);
        row_rem_fix   = row_wrap ? (r_rem - 10'(ROW_LENGTH)) : r_rem;
        mirrored      = ADDR_W'(r_idx) + ADDR_W'(ROW_LENGTH - 1)
                        - ADDR_W'({row_rem_fix, 1'b0});
        strip_wrap    = (r_rem >= 10'(STRIP_LENGTH));
        strip_fix     = r_q + 7'(strip_wrap);
        off_fix       = strip_wrap ? (r_rem - 10'(STRIP_LENGTH)) : r_rem;
        strip_drop    = (strip_fix >= 7'(STRIP_COUNT));
        base          = {r_rem, 4'b0000} + {1'b0, r_rem, 3'b000};
    end

    // outputs
    always_comb begin
        o_in_ready    = (r_state == F_IDLE) && !i_clearing;
        accept        = i_in_valid && o_in_ready;
        o_push        = (r_state == F_PUSH) && !i_full;
        o_job.is_read = (r_cmd == CMD_READ);
        o_job.addr    = (r_cmd == CMD_READ) ? r_addr : ADDR_W'(base);
        o_job.strip   = r_q[LANE_W-1:0];
        o_job.grb     = to_grb(r_color);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    if (t_command'(i_command) == CMD_READ) begin
                        n_state = F_PUSH;
                    end else if (i_pixel_index < INDEX_W'(PIXEL_COUNT)) begin
                        n_state = F_ROW_EST;
                    end
                end
            end
            F_ROW_EST:   n_state = F_ROW_REM;
            F_ROW_REM:   n_state = F_MIRROR;
            F_MIRROR:    n_state = F_STRIP_EST;
            F_STRIP_EST: n_state = F_STRIP_REM;
            F_STRIP_REM: n_state = F_STRIP_FIX;
            F_STRIP_FIX: n_state = strip_drop ? F_IDLE : F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default:     n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    r_cmd   <= t_command'(i_command);
                    r_idx   <= i_pixel_index;
                    r_color <= i_pixel_color;
                    r_addr  <= i_byte_address;
                end
            end
            F_ROW_EST: r_q   <= row_prod[22:16];
            F_ROW_REM: r_rem <= 10'(row_rem_raw);
            F_MIRROR: begin
                if (!row_fix[0]) begin
                    r_idx <= INDEX_W'(mirrored);
                end
            end
            F_STRIP_EST: r_q   <= strip_prod[22:16];
            F_STRIP_REM: r_rem <= 10'(strip_rem_raw);
            F_STRIP_FIX: begin
                r_q   <= strip_fix;
                r_rem <= off_fix;
            end
            default: ;
        endcase
    end

endmodule

@@ src/lbfw_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfw_queue
// short job queue between the command front end and the store sequencer
// ----------------------------------------------------------------------------
module lbfw_queue import lbfw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ src/lbfw_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfw_back
// frame store with clearing pass, 24-byte read-modify-write per pixel and
// registered read result
// ----------------------------------------------------------------------------
module lbfw_back import lbfw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_job              i_job,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_read_data,
    output logic [ADDR_W-1:0] o_read_address
);

    logic [7:0]         r_store [STORE_DEPTH];
    logic [7:0]         r_rd_data;

    t_back_state        r_state, n_state;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [ADDR_W-1:0]  r_base;
    logic [LANE_W-1:0]  r_strip;
    logic [COLOR_W-1:0] r_grb;
    logic [4:0]         r_cnt;
    logic               r_oob;
    logic               r_out_valid;
    logic [7:0]         r_out_data;
    logic [ADDR_W-1:0]  r_out_addr;

    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         wr_data;
    logic [7:0]         lane;

    assign lane           = 8'b1 << r_strip;
    assign o_clearing     = (r_state == B_CLEAR);
    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_out_data;
    assign o_read_address = r_out_addr;

    // outputs
    always_comb begin
        o_pop   = 1'b0;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        wr_addr = r_clr_addr;
        rd_addr = i_job.addr;
        wr_data = 8'h00;
        unique case (r_state)
            B_CLEAR: mem_we = 1'b1;
            B_IDLE: begin
                if (!i_empty) begin
                    if (i_job.is_read) begin
                        if (!r_out_valid) begin
                            o_pop  = 1'b1;
                            mem_re = (i_job.addr < STORE_BYTES);
                        end
                    end else begin
                        o_pop = 1'b1;
                    end
                end
            end
            B_RMW: begin
                mem_re  = (r_cnt < 5'(BITS_PER_PIXEL));
                rd_addr = r_base + ADDR_W'(r_cnt);
                mem_we  = (r_cnt != '0);
                wr_addr = r_base + ADDR_W'(r_cnt) - ADDR_W'(1);
                wr_data = (r_rd_data & ~lane) | (r_grb[COLOR_W-1] ? lane : 8'h00);
            end
            B_READ: ;
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: begin
                if (r_clr_addr == STORE_BYTES - ADDR_W'(1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (o_pop) begin
                    n_state = i_job.is_read ? B_READ : B_RMW;
                end
            end
            B_RMW: begin
                if (r_cnt == 5'(BITS_PER_PIXEL)) begin
                    n_state = B_IDLE;
                end
            end
            B_READ:  n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (r_state == B_READ) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_base  <= i_job.addr;
            r_strip <= i_job.strip;
            r_grb   <= i_job.grb;
            r_cnt   <= '0;
            r_oob   <= (i_job.addr >= STORE_BYTES);
        end else if (r_state == B_RMW) begin
            r_cnt <= r_cnt + 5'd1;
            if (mem_we) begin
                r_grb <= r_grb << 1;
            end
        end
        if (r_state == B_READ) begin
            r_out_data <= r_oob ? 8'h00 : r_rd_data;
            r_out_addr <= r_base;
        end
    end

    // frame store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

endmodule

@@ src/led_bitplane_frame_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_bitplane_frame_writer
// bit-plane frame store for eight parallel led strips of 300 pixels
// ----------------------------------------------------------------------------
// input channel (i_in_valid / o_in_ready) takes one command per transaction:
// set writes a pixel colour as grb into bit 'strip' of 24 consecutive bytes,
// read returns one stored byte on the output channel (o_out_valid /
// i_out_ready) with its address echoed. set gives no output transaction.
// out-of-range pixel indices and strips are dropped; reads beyond the store
// return zero.
// a set passes the front end's row split, mirror and strip split steps, then
// the store sequencer's 24 read-modify-writes through the single byte-wide
// store. the front end takes no new command until it is done with the last.
// a read passes the front end's push state, the queue and the sequencer's
// idle and read states before o_out_valid rises; the sequencer takes no new
// read while a result is still held.
// a four-entry queue sits between front end and sequencer; a held result
// does not stop the front end accepting until the queue fills.
// after reset the store is cleared, one byte a cycle, through all 7200 bytes,
// during which o_in_ready stays low.
// a stalled result holds o_out_valid and its payload until taken.
// ----------------------------------------------------------------------------
module led_bitplane_frame_writer import lbfw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [0:0]         i_command,
    input  logic [INDEX_W-1:0] i_pixel_index,
    input  logic [COLOR_W-1:0] i_pixel_color,
    input  logic [ADDR_W-1:0]  i_byte_address,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_read_data,
    output logic [ADDR_W-1:0]  o_read_address
);

    logic clearing;
    logic full;
    logic empty;
    logic push;
    logic pop;
    t_job push_job;
    t_job head_job;

    lbfw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_pixel_index  (i_pixel_index),
        .i_pixel_color  (i_pixel_color),
        .i_byte_address (i_byte_address),
        .i_clearing     (clearing),
        .i_full         (full),
        .o_push         (push),
        .o_job          (push_job)
    );

    lbfw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (head_job)
    );

    lbfw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_job          (head_job),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_data    (o_read_data),
        .o_read_address (o_read_address)
    );

endmodule

@@ src/lbfw_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfw_checker
// port-level checks on the frame writer, bound to the top level
// ----------------------------------------------------------------------------
module lbfw_checker import lbfw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  logic [0:0]         i_command,
    input  logic [INDEX_W-1:0] i_pixel_index,
    input  logic [COLOR_W-1:0] i_pixel_color,
    input  logic [ADDR_W-1:0]  i_byte_address,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic [7:0]         o_read_data,
    input  logic [ADDR_W-1:0]  o_read_address
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_read_data) && $stable(o_read_address))
        else $error("stalled result changed");

    // reset starts the clearing pass with nothing to deliver
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("not idle after reset");

    // reads beyond the store return zero
    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_read_address >= STORE_BYTES) |-> o_read_data == 8'h00)
        else $error("out-of-range read returned data");

    // an accepted read occupies the front end for the next cycle
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (t_command'(i_command) == CMD_READ)
            |=> !o_in_ready)
        else $error("front end ready straight after a read");

endmodule

bind led_bitplane_frame_writer lbfw_checker u_checker (.*);
